// ===== hw/rtl/b2da_pkg.sv =====
// shared types and constants for the binary to decimal ascii unit
// no dependencies; used by b2da_cell and binary_to_decimal_ascii_unit
package b2da_pkg;

    localparam int VALUE_BITS  = 64;
    localparam int NUM_DIGITS  = 20;
    localparam int PAD_DIGITS  = 3;
    localparam int BIT_CNT_W   = $clog2(VALUE_BITS);
    localparam int DIG_CNT_W   = $clog2(NUM_DIGITS + 1);
    localparam int CHAR_W      = 6;
    localparam int ASCII_ZERO  = 48;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } t_state;

    // per-cycle commands broadcast along the digit chain
    typedef struct packed {
        logic clear;
        logic shift_bit;
        logic shift_digit;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/b2da_cell.sv =====
// one bcd digit cell of the shift-and-add-3 chain
// depends on b2da_pkg for the control struct
module b2da_cell (
    input  logic                 i_clk,
    input  b2da_pkg::t_cell_ctl  i_ctl,
    input  logic                 i_carry,
    input  logic [3:0]           i_digit,
    output logic                 o_carry,
    output logic [3:0]           o_digit
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] w_adj;

    // add-3 correction ahead of the bit shift
    assign w_adj   = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
    assign o_carry = w_adj[3];
    assign o_digit = r_digit;

    // next digit: clear, shift one bit in from below, or take the lower digit
    always_comb begin
        n_digit = r_digit;
        if (i_ctl.clear) begin
            n_digit = 4'd0;
        end else if (i_ctl.shift_bit) begin
            n_digit = {w_adj[2:0], i_carry};
        end else if (i_ctl.shift_digit) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

// ===== hw/rtl/binary_to_decimal_ascii_unit.sv =====
// binary to decimal ascii unit: 20 bcd cells fed one bit a cycle, built from b2da_cell
// with types and constants from b2da_pkg
// sequence: accept, the bit-serial conversion, then a leading-zero skip that shifts the
// digit chain up while the top digit is zero, then m characters at one per cycle while the
// sink is ready; m is the digit count, at least three with padding
// a new number is accepted only after the last character of the previous one is emitted
// reset: synchronous active-low, returns the controller to idle, output empty
module binary_to_decimal_ascii_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // value[63:0]
    input  logic        i_s_tuser,   // pad_three
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // digit_char[5:0], zeros[7:6]
    output logic        o_m_tlast
);

    localparam int ND = b2da_pkg::NUM_DIGITS;

    b2da_pkg::t_state    r_state;
    b2da_pkg::t_state    n_state;
    b2da_pkg::t_cell_ctl w_ctl;

    logic [b2da_pkg::VALUE_BITS-1:0] r_val;
    logic                            r_pad;
    logic [b2da_pkg::BIT_CNT_W-1:0]  r_bit;
    logic [b2da_pkg::DIG_CNT_W-1:0]  r_left;
    logic [b2da_pkg::DIG_CNT_W-1:0]  w_min;
    logic                            r_out_valid;
    logic [b2da_pkg::CHAR_W-1:0]     r_out_char;
    logic                            r_out_last;

    logic       w_accept;
    logic       w_bit_done;
    logic       w_top_zero;
    logic       w_can_skip;
    logic       w_out_free;
    logic       w_emit;
    logic [3:0] w_digit [ND];
    logic       w_carry [ND];

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_bit_done = (r_bit == b2da_pkg::BIT_CNT_W'(b2da_pkg::VALUE_BITS - 1));
    assign w_top_zero = (w_digit[ND-1] == 4'd0);
    assign w_min      = r_pad ? b2da_pkg::DIG_CNT_W'(b2da_pkg::PAD_DIGITS)
                              : b2da_pkg::DIG_CNT_W'(1);
    assign w_can_skip = w_top_zero && (r_left > w_min);
    assign w_out_free = !r_out_valid || i_m_tready;

    // digit chain, cell 0 least significant
    for (genvar g = 0; g < ND; g++) begin : g_cells
        if (g == 0) begin : g_first
            b2da_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_carry (r_val[b2da_pkg::VALUE_BITS-1]),
                .i_digit (4'd0),
                .o_carry (w_carry[g]),
                .o_digit (w_digit[g])
            );
        end else begin : g_rest
            b2da_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_carry (w_carry[g-1]),
                .i_digit (w_digit[g-1]),
                .o_carry (w_carry[g]),
                .o_digit (w_digit[g])
            );
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            b2da_pkg::ST_IDLE: if (w_accept) n_state = b2da_pkg::ST_CONV;
            b2da_pkg::ST_CONV: if (w_bit_done) n_state = b2da_pkg::ST_SKIP;
            b2da_pkg::ST_SKIP: if (!w_can_skip) n_state = b2da_pkg::ST_EMIT;
            b2da_pkg::ST_EMIT: begin
                if (w_out_free && (r_left == b2da_pkg::DIG_CNT_W'(1))) begin
                    n_state = b2da_pkg::ST_IDLE;
                end
            end
            default: n_state = b2da_pkg::ST_IDLE;
        endcase
    end

    // controller outputs, input ready only out of reset
    always_comb begin
        o_s_tready        = 1'b0;
        w_ctl.clear       = 1'b0;
        w_ctl.shift_bit   = 1'b0;
        w_ctl.shift_digit = 1'b0;
        w_emit            = 1'b0;
        unique case (r_state)
            b2da_pkg::ST_IDLE: begin
                o_s_tready  = i_rst_n;
                w_ctl.clear = i_s_tvalid && i_rst_n;
            end
            b2da_pkg::ST_CONV: w_ctl.shift_bit = 1'b1;
            b2da_pkg::ST_SKIP: w_ctl.shift_digit = w_can_skip;
            b2da_pkg::ST_EMIT: begin
                w_emit            = w_out_free;
                w_ctl.shift_digit = w_out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= b2da_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // value shifter, counters and output word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_val <= i_s_tdata;
            r_pad <= i_s_tuser;
            r_bit <= '0;
        end else if (w_ctl.shift_bit) begin
            r_val <= {r_val[b2da_pkg::VALUE_BITS-2:0], 1'b0};
            r_bit <= r_bit + b2da_pkg::BIT_CNT_W'(1);
        end
        if (w_ctl.shift_bit && w_bit_done) begin
            r_left <= b2da_pkg::DIG_CNT_W'(ND);
        end else if (w_ctl.shift_digit) begin
            r_left <= r_left - b2da_pkg::DIG_CNT_W'(1);
        end
        if (w_emit) begin
            r_out_char <= b2da_pkg::CHAR_W'(b2da_pkg::ASCII_ZERO + int'(w_digit[ND-1]));
            r_out_last <= (r_left == b2da_pkg::DIG_CNT_W'(1));
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_char};
    assign o_m_tlast  = r_out_last;

    // a word only enters the output while emitting with digits left
    a_emit_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (r_left != '0))
        else $error("emit with no digits left");

    // the top cell never holds a non-decimal code once conversion is over
    a_top_bcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == b2da_pkg::ST_SKIP || r_state == b2da_pkg::ST_EMIT)
        |-> (w_digit[ND-1] <= 4'd9))
        else $error("top digit out of range");

    // a nonzero top digit ends the leading-zero skip
    a_skip_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == b2da_pkg::ST_SKIP && !w_top_zero) |=> (r_state == b2da_pkg::ST_EMIT))
        else $error("skip ran past a significant digit");

    // the emit state never runs with an empty digit count
    a_skip_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == b2da_pkg::ST_EMIT) |-> (r_left != '0))
        else $error("emit state with empty digit count");

endmodule
